FILE: src/mmrn_pkg.sv
package mmrn_pkg;

    localparam int VAL_W           = 16;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int QUOT_W          = 20;
    localparam int CNT_W           = 5;
    localparam int SUM_W           = 22;
    localparam int SPAN_ONE        = 256;
    localparam int OUT_MIN         = -32768;
    localparam int OUT_MAX         = 32767;
    localparam int CFG_IDX_W       = 1;

    localparam logic [QUOT_W-1:0]    MAG_LIMIT       = 20'h40000;
    localparam logic signed [VAL_W-1:0] TARGET_LOW_RST  = 16'sd0;
    localparam logic signed [VAL_W-1:0] TARGET_HIGH_RST = 16'sd256;

    localparam logic [CFG_IDX_W-1:0] REG_TARGET_LOW  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_HIGH = 1'b1;

    localparam logic KIND_OBSERVE = 1'b0;
    localparam logic KIND_MAP     = 1'b1;

    typedef struct packed {
        logic              sat;
        logic [QUOT_W-1:0] mag;
    } t_mmrn_res;

endpackage

FILE: src/mmrn_muldiv.sv
module mmrn_muldiv
    import mmrn_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [SAMPLE_BITS:0] i_ad,
    input  logic [VAL_W-1:0]     i_range,
    input  logic [SAMPLE_BITS:0] i_span,
    output logic                 o_done,
    output t_mmrn_res            o_res
);

    localparam int AW = SAMPLE_BITS + 1;
    localparam int PW = AW + VAL_W;
    localparam int RW = AW + 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_CHK  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]        r_state;
    logic [2:0]        n_state;
    logic [CNT_W-1:0]  r_cnt;
    logic [AW-1:0]     r_ad;
    logic [AW-1:0]     r_span;
    logic [AW-1:0]     r_acc;
    logic [VAL_W-1:0]  r_plo;
    logic [RW-1:0]     r_rem;
    logic [QUOT_W-1:0] r_low;
    logic [QUOT_W-1:0] r_quo;
    logic              r_sat;

    logic [AW:0]       w_sum;
    logic [PW-1:0]     w_prod;
    logic [AW-1:0]     w_head;
    logic              w_sat;
    logic [RW-1:0]     w_trial;
    logic              w_ge;

    // shift-add multiply, LSB first: product low bits shift into r_plo
    assign w_sum   = {1'b0, r_acc} + (r_plo[0] ? {1'b0, r_ad} : '0);
    assign w_prod  = {r_acc, r_plo};
    assign w_head  = AW'(w_prod[PW-1:QUOT_W]);
    assign w_sat   = (w_head >= r_span);
    // restoring division, one quotient bit per cycle
    assign w_trial = {r_rem[RW-2:0], r_low[QUOT_W-1]};
    assign w_ge    = (w_trial >= RW'(r_span));

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                if (r_cnt == CNT_W'(VAL_W - 1)) begin
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                n_state = w_sat ? S_DONE : S_DIV;
            end
            S_DIV: begin
                if (r_cnt == CNT_W'(QUOT_W - 1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_ad   <= i_ad;
                r_span <= i_span;
                r_plo  <= i_range;
                r_acc  <= '0;
                r_cnt  <= '0;
            end
            S_MUL: begin
                r_acc <= w_sum[AW:1];
                r_plo <= {w_sum[0], r_plo[VAL_W-1:1]};
                r_cnt <= r_cnt + 1'b1;
            end
            S_CHK: begin
                r_sat <= w_sat;
                r_rem <= RW'(w_head);
                r_low <= w_prod[QUOT_W-1:0];
                r_quo <= '0;
                r_cnt <= '0;
            end
            S_DIV: begin
                r_rem <= w_ge ? (w_trial - RW'(r_span)) : w_trial;
                r_quo <= {r_quo[QUOT_W-2:0], w_ge};
                r_low <= {r_low[QUOT_W-2:0], 1'b0};
                r_cnt <= r_cnt + 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign o_done    = (r_state == S_DONE);
    assign o_res.sat = r_sat;
    assign o_res.mag = r_quo;

endmodule

FILE: src/min_max_range_normalizer.sv
// Min-max range normalizer.
// Input channel (i_in_valid / o_in_stall) carries a kind bit and a signed Q8.8
// sample. Observe words (kind 0) update the tracked low and high sample; the
// first observe after reset or after any map word restarts tracking. Map words
// (kind 1) produce one output word on o_out_valid / i_out_stall:
//   min(target_lo, target_hi) + (v - low) * |target_hi - target_lo| / span, saturated to 16 bits.
// Target bounds are written on the config channel (index 0 and 1); the user must
// write them only while idle: the block itself does not enforce it. Observe words
// do not stall the input. A map word stalls the input during a bit-serial
// multiply over the target span and a restoring divide over the observed span
// (skipped when the quotient saturates early); the next word can be taken in the
// same cycle that its result is shown. A finished result sits in the output
// register while the next words are taken; a result that cannot be handed over
// holds the map engine until the receiver stops stalling. Reset clears tracking
// to 0/0 with restart pending, sets the target range to 0..1.0 and empties the output register.
module min_max_range_normalizer
    import mmrn_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_kind,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_value,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [VAL_W-1:0]       o_scaled_value,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [VAL_W-1:0]              i_cfg_data
);

    localparam int AW = SAMPLE_BITS + 1;

    localparam logic [1:0] T_IDLE  = 2'd0;
    localparam logic [1:0] T_SETUP = 2'd1;
    localparam logic [1:0] T_WAIT  = 2'd2;
    localparam logic [1:0] T_FIN   = 2'd3;

    logic [1:0]                    r_state;
    logic [1:0]                    n_state;
    logic signed [VAL_W-1:0]       r_target_low;
    logic signed [VAL_W-1:0]       r_target_high;
    logic signed [SAMPLE_BITS-1:0] r_seen_low;
    logic signed [SAMPLE_BITS-1:0] r_seen_high;
    logic                          r_restart;
    logic signed [SAMPLE_BITS-1:0] r_v;
    logic signed [VAL_W-1:0]       r_lo;
    logic                          r_neg;
    t_mmrn_res                     r_res;
    logic                          r_out_valid;
    logic signed [VAL_W-1:0]       r_out_value;

    logic                          w_in_acc;
    logic                          w_out_free;
    logic signed [AW-1:0]          w_d;
    logic [AW-1:0]                 w_ad;
    logic [AW-1:0]                 w_span;
    logic [AW-1:0]                 w_span_eff;
    logic                          w_swap;
    logic signed [VAL_W-1:0]       w_lo;
    logic signed [VAL_W-1:0]       w_hi;
    logic [VAL_W-1:0]              w_range_x;
    logic                          w_done;
    t_mmrn_res                     w_res;
    logic [SUM_W-1:0]              w_mag_x;
    logic [SUM_W-1:0]              w_off;
    logic signed [SUM_W-1:0]       w_sum;
    logic signed [VAL_W-1:0]       w_result;

    assign o_in_stall  = (r_state != T_IDLE);
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_cfg_ready = 1'b1;

    // setup terms for the serial unit
    assign w_d        = {r_v[SAMPLE_BITS-1], r_v} - {r_seen_low[SAMPLE_BITS-1], r_seen_low};
    assign w_ad       = w_d[AW-1] ? (~w_d + 1'b1) : w_d;
    assign w_span     = {r_seen_high[SAMPLE_BITS-1], r_seen_high}
                      - {r_seen_low[SAMPLE_BITS-1], r_seen_low};
    assign w_span_eff = (w_span == '0) ? AW'(SPAN_ONE) : w_span;
    assign w_swap     = (r_target_low > r_target_high);
    assign w_lo       = w_swap ? r_target_high : r_target_low;
    assign w_hi       = w_swap ? r_target_low : r_target_high;
    // hi >= lo, so the difference always fits unsigned in VAL_W bits
    assign w_range_x  = w_hi - w_lo;

    mmrn_muldiv #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == T_SETUP),
        .i_ad    (w_ad),
        .i_range (w_range_x),
        .i_span  (w_span_eff),
        .o_done  (w_done),
        .o_res   (w_res)
    );

    // final add and clamp
    assign w_mag_x = {{(SUM_W - QUOT_W){1'b0}}, r_res.mag};
    assign w_off   = r_neg ? (~w_mag_x + 1'b1) : w_mag_x;
    assign w_sum   = {{(SUM_W - VAL_W){r_lo[VAL_W-1]}}, r_lo} + w_off;

    always_comb begin
        if (r_res.sat || (r_res.mag > MAG_LIMIT)) begin
            w_result = r_neg ? VAL_W'(OUT_MIN) : VAL_W'(OUT_MAX);
        end else if (w_sum < SUM_W'(OUT_MIN)) begin
            w_result = VAL_W'(OUT_MIN);
        end else if (w_sum > SUM_W'(OUT_MAX)) begin
            w_result = VAL_W'(OUT_MAX);
        end else begin
            w_result = w_sum[VAL_W-1:0];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            T_IDLE: begin
                if (w_in_acc && (i_kind == KIND_MAP)) begin
                    n_state = T_SETUP;
                end
            end
            T_SETUP: begin
                n_state = T_WAIT;
            end
            T_WAIT: begin
                if (w_done) begin
                    n_state = T_FIN;
                end
            end
            T_FIN: begin
                if (w_out_free) begin
                    n_state = T_IDLE;
                end
            end
            default: begin
                n_state = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= T_IDLE;
            r_target_low  <= TARGET_LOW_RST;
            r_target_high <= TARGET_HIGH_RST;
            r_seen_low    <= '0;
            r_seen_high   <= '0;
            r_restart     <= 1'b1;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_TARGET_LOW:  r_target_low  <= i_cfg_data;
                    REG_TARGET_HIGH: r_target_high <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (w_in_acc) begin
                if (i_kind == KIND_MAP) begin
                    r_restart <= 1'b1;
                end else if (r_restart) begin
                    r_seen_low  <= i_sample_value;
                    r_seen_high <= i_sample_value;
                    r_restart   <= 1'b0;
                end else if (i_sample_value < r_seen_low) begin
                    r_seen_low <= i_sample_value;
                end else if (i_sample_value > r_seen_high) begin
                    r_seen_high <= i_sample_value;
                end
            end
            if ((r_state == T_FIN) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_v <= i_sample_value;
        end
        if (r_state == T_SETUP) begin
            r_lo  <= w_lo;
            r_neg <= w_d[AW-1];
        end
        if (w_done) begin
            r_res <= w_res;
        end
        if ((r_state == T_FIN) && w_out_free) begin
            r_out_value <= w_result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_scaled_value = r_out_value;

endmodule

FILE: src/mmrn_checker.sv
module mmrn_checker
    import mmrn_pkg::*;
(
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_in_valid,
    input logic                    o_in_stall,
    input logic                    i_kind,
    input logic                    o_out_valid,
    input logic                    i_out_stall,
    input logic signed [VAL_W-1:0] o_scaled_value
);

    // reset leaves the block empty and ready
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_in_stall && !o_out_valid))
        else $error("block not empty after reset");

    // a stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_scaled_value)))
        else $error("stalled output word changed");

    // observe words never produce a result
    a_observe_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && (i_kind == KIND_OBSERVE) && !o_out_valid)
        |=> !o_out_valid)
        else $error("observe word produced output");

    // a map word occupies the engine
    a_map_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && (i_kind == KIND_MAP)) |=> o_in_stall)
        else $error("map word did not hold the input");

endmodule

bind min_max_range_normalizer mmrn_checker u_mmrn_checker (.*);
